// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbs assertion violated");

// Next-cycle implication.
`define PBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbs assertion violated");

`endif

// ===== src/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared constants and state types of the path point box smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package pbs_pkg;

  // Default sizing of the block.
  localparam int MAX_HALF_WINDOW_DEF   = 15;
  localparam int MAX_STROKE_POINTS_DEF = 16384;
  localparam int COORD_BITS_DEF        = 14;

  // Half-window register.
  localparam int              CFG_W             = 4;
  localparam logic [CFG_W-1:0] HALF_WINDOW_RESET = 4'd7;
  // Register values up to this one turn smoothing off.
  localparam logic [CFG_W-1:0] SMOOTH_OFF_MAX    = 4'd1;

  // Most results that one input beat may release.
  localparam int MAX_RESULTS = 16;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EVAL,
    FS_EMIT,
    FS_SLIDE
  } front_state_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_DONE
  } back_state_e;

endpackage

`default_nettype wire

// ===== src/pbs_if.sv =====
// ----------------------------------------------------------------------------
// pbs_if
// Valid/ready channel interfaces: configuration, input points, results.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbs_cfg_if import pbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] half_window;

  modport source (output valid, output half_window, input ready);
  modport sink   (input valid, input half_window, output ready);
endinterface

interface pbs_point_if import pbs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface pbs_smooth_if import pbs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] smooth_x;
  logic [COORD_BITS-1:0] smooth_y;
  logic                  stroke_end;

  modport source (output valid, output smooth_x, output smooth_y, output stroke_end,
                  input ready);
  modport sink   (input valid, input smooth_x, input smooth_y, input stroke_end,
                  output ready);
endinterface

`default_nettype wire

// ===== src/pbs_fifo.sv =====
// ----------------------------------------------------------------------------
// pbs_fifo
// Short register queue carrying division jobs from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_fifo import pbs_pkg::*; #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output logic [DATA_W-1:0]      pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/pbs_front.sv =====
// ----------------------------------------------------------------------------
// pbs_front
// Accepts points, keeps the point ring and running window sums, and issues
// one division job per smoothed point.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_front import pbs_pkg::*; #(
  parameter int MAX_HALF_WINDOW   = MAX_HALF_WINDOW_DEF,
  parameter int MAX_STROKE_POINTS = MAX_STROKE_POINTS_DEF,
  parameter int COORD_BITS        = COORD_BITS_DEF,
  parameter int CNT_W             = $clog2(2 * MAX_HALF_WINDOW + 2),
  parameter int SUM_W             = COORD_BITS + CNT_W,
  parameter int JOB_W             = 2 * SUM_W + CNT_W + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [CFG_W-1:0]      half_window_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [COORD_BITS-1:0] point_x_i,
  input  wire logic [COORD_BITS-1:0] point_y_i,
  input  wire logic                  last_point_i,
  output logic                       job_valid_o,
  input  wire logic                  job_ready_i,
  output logic [JOB_W-1:0]           job_data_o
);

  localparam int HALF_W = $clog2(MAX_HALF_WINDOW + 1);
  localparam int PTS_W  = $clog2(MAX_STROKE_POINTS + 1);
  localparam int IDX_W  = PTS_W + 1;
  localparam int RING_W = $clog2(2 * MAX_HALF_WINDOW + 1);
  localparam int RING_D = 1 << RING_W;
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int C      = COORD_BITS;

  front_state_e state_q, state_d;

  logic [PTS_W-1:0]  seen_q, seen_d;
  logic [PTS_W-1:0]  emitted_q, emitted_d;
  logic [SUM_W-1:0]  sum_x_q, sum_x_d;
  logic [SUM_W-1:0]  sum_y_q, sum_y_d;
  logic [HALF_W-1:0] half_q, half_d;
  logic              last_q, last_d;
  logic [RES_W-1:0]  nres_q, nres_d;
  logic              sub_en_q, add_en_q;

  logic [2*C-1:0]    ring_mem_q [RING_D];
  logic [2*C-1:0]    rd_old_q, rd_new_q;

  logic              accept, store, emit_fire, emit_go;
  logic [HALF_W-1:0] half_new;
  logic [IDX_W-1:0]  e_w, h_w, seen_w, lo_w, hi_w, top_w, nxt_w, cnt_w;
  logic              sub_en, add_en, end_flag;

  assign accept    = (state_q == FS_IDLE) && in_valid_i;
  assign store     = accept && (seen_q < PTS_W'(MAX_STROKE_POINTS));
  assign emit_fire = (state_q == FS_EMIT) && job_ready_i;

  // Half-window taken for a new stroke: small values disable smoothing, large ones are clamped.
  always_comb begin
    if (half_window_i <= SMOOTH_OFF_MAX) begin
      half_new = '0;
    end else if (int'(half_window_i) > MAX_HALF_WINDOW) begin
      half_new = HALF_W'(MAX_HALF_WINDOW);
    end else begin
      half_new = HALF_W'(half_window_i);
    end
  end

  // Window bounds of the point being emitted.
  always_comb begin
    e_w      = IDX_W'(emitted_q);
    h_w      = IDX_W'(half_q);
    seen_w   = IDX_W'(seen_q);
    sub_en   = (e_w >= h_w);
    lo_w     = sub_en ? (e_w - h_w) : '0;
    top_w    = e_w + h_w;
    hi_w     = (top_w > seen_w - IDX_W'(1)) ? (seen_w - IDX_W'(1)) : top_w;
    cnt_w    = hi_w - lo_w + IDX_W'(1);
    nxt_w    = e_w + IDX_W'(1) + h_w;
    add_en   = (nxt_w < seen_w);
    // Only the flush at the end of a stroke marks its final point.
    end_flag = last_q && (e_w + IDX_W'(1) == seen_w);
  end

  assign job_data_o = {end_flag, CNT_W'(cnt_w), sum_y_q, sum_x_q};

  always_comb begin
    if (!last_q) begin
      emit_go = ((seen_q - emitted_q) > PTS_W'(half_q));
    end else begin
      emit_go = (emitted_q < seen_q) && (nres_q < RES_W'(MAX_RESULTS));
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_IDLE:  if (in_valid_i) state_d = FS_EVAL;
      FS_EVAL:  state_d = emit_go ? FS_EMIT : FS_IDLE;
      FS_EMIT:  if (job_ready_i) state_d = FS_SLIDE;
      FS_SLIDE: state_d = FS_EVAL;
      default:  state_d = FS_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    job_valid_o = 1'b0;
    unique case (state_q)
      FS_IDLE: in_ready_o  = 1'b1;
      FS_EMIT: job_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        job_valid_o = 1'b0;
      end
    endcase
  end

  // Counters and running sums.
  always_comb begin
    seen_d    = seen_q;
    emitted_d = emitted_q;
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    half_d    = half_q;
    last_d    = last_q;
    nres_d    = nres_q;
    if (accept) begin
      last_d = last_point_i;
      nres_d = '0;
      if (seen_q == '0) begin
        half_d = half_new;
      end
      if (store) begin
        seen_d  = seen_q + PTS_W'(1);
        sum_x_d = sum_x_q + SUM_W'(point_x_i);
        sum_y_d = sum_y_q + SUM_W'(point_y_i);
      end
    end
    if (emit_fire) begin
      emitted_d = emitted_q + PTS_W'(1);
      nres_d    = nres_q + RES_W'(1);
    end
    if (state_q == FS_SLIDE) begin
      sum_x_d = sum_x_q - (sub_en_q ? SUM_W'(rd_old_q[C-1:0]) : '0)
                        + (add_en_q ? SUM_W'(rd_new_q[C-1:0]) : '0);
      sum_y_d = sum_y_q - (sub_en_q ? SUM_W'(rd_old_q[2*C-1:C]) : '0)
                        + (add_en_q ? SUM_W'(rd_new_q[2*C-1:C]) : '0);
    end
    // Stroke closed: start the next one from empty.
    if ((state_q == FS_EVAL) && !emit_go && last_q) begin
      seen_d    = '0;
      emitted_d = '0;
      sum_x_d   = '0;
      sum_y_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= FS_IDLE;
      seen_q    <= '0;
      emitted_q <= '0;
      sum_x_q   <= '0;
      sum_y_q   <= '0;
      half_q    <= '0;
      last_q    <= 1'b0;
      nres_q    <= '0;
      sub_en_q  <= 1'b0;
      add_en_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      seen_q    <= seen_d;
      emitted_q <= emitted_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      half_q    <= half_d;
      last_q    <= last_d;
      nres_q    <= nres_d;
      if (emit_fire) begin
        sub_en_q <= sub_en;
        add_en_q <= add_en;
      end
    end
  end

  // Point ring: one write per stored point, two registered reads per emitted point.
  always_ff @(posedge clk_i) begin
    if (store) begin
      ring_mem_q[seen_q[RING_W-1:0]] <= {point_y_i, point_x_i};
    end
    if (emit_fire) begin
      rd_old_q <= ring_mem_q[lo_w[RING_W-1:0]];
      rd_new_q <= ring_mem_q[nxt_w[RING_W-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== src/pbs_back.sv =====
// ----------------------------------------------------------------------------
// pbs_back
// Divides both window sums by the point count, one quotient bit per cycle,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbs_back import pbs_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int CNT_W      = 5,
  parameter int SUM_W      = COORD_BITS + CNT_W,
  parameter int JOB_W      = 2 * SUM_W + CNT_W + 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire logic [JOB_W-1:0] job_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [COORD_BITS-1:0] smooth_x_o,
  output logic [COORD_BITS-1:0] smooth_y_o,
  output logic                  stroke_end_o
);

  localparam int C      = COORD_BITS;
  localparam int STEP_W = $clog2(C);

  back_state_e state_q, state_d;

  // The mean never exceeds the largest coordinate, so the high part of the
  // sum is below the count and only C quotient bits are needed.
  logic [CNT_W-1:0]  rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [C-1:0]      nq_x_q, nq_x_d, nq_y_q, nq_y_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              end_q;
  logic [STEP_W-1:0] step_q;
  logic              out_valid_q;

  logic [SUM_W-1:0]  job_sx, job_sy;
  logic [CNT_W:0]    t_x, t_y;
  logic              ge_x, ge_y;
  logic              load_job, step_last, out_load;

  assign job_sx    = job_data_i[SUM_W-1:0];
  assign job_sy    = job_data_i[2*SUM_W-1:SUM_W];
  assign load_job  = (state_q == BS_IDLE) && job_valid_i;
  assign step_last = (step_q == STEP_W'(C - 1));
  assign out_load  = (state_q == BS_DONE) && (!out_valid_q || out_ready_i);

  // One restoring step for each coordinate.
  always_comb begin
    t_x     = {rem_x_q, nq_x_q[C-1]};
    t_y     = {rem_y_q, nq_y_q[C-1]};
    ge_x    = (t_x >= {1'b0, cnt_q});
    ge_y    = (t_y >= {1'b0, cnt_q});
    rem_x_d = ge_x ? CNT_W'(t_x - {1'b0, cnt_q}) : t_x[CNT_W-1:0];
    rem_y_d = ge_y ? CNT_W'(t_y - {1'b0, cnt_q}) : t_y[CNT_W-1:0];
    nq_x_d  = {nq_x_q[C-2:0], ge_x};
    nq_y_d  = {nq_y_q[C-2:0], ge_y};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BS_IDLE: if (job_valid_i) state_d = BS_DIV;
      BS_DIV:  if (step_last) state_d = BS_DONE;
      BS_DONE: if (!out_valid_q || out_ready_i) state_d = BS_IDLE;
      default: state_d = BS_IDLE;
    endcase
  end

  always_comb begin
    job_ready_o = 1'b0;
    unique case (state_q)
      BS_IDLE: job_ready_o = 1'b1;
      default: job_ready_o = 1'b0;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_job) begin
        step_q <= '0;
      end else if (state_q == BS_DIV) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_job) begin
      rem_x_q <= job_sx[SUM_W-1:C];
      rem_y_q <= job_sy[SUM_W-1:C];
      nq_x_q  <= job_sx[C-1:0];
      nq_y_q  <= job_sy[C-1:0];
      cnt_q   <= job_data_i[2*SUM_W+CNT_W-1:2*SUM_W];
      end_q   <= job_data_i[JOB_W-1];
    end else if (state_q == BS_DIV) begin
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
      nq_x_q  <= nq_x_d;
      nq_y_q  <= nq_y_d;
    end
    if (out_load) begin
      smooth_x_o   <= nq_x_q;
      smooth_y_o   <= nq_y_q;
      stroke_end_o <= end_q;
    end
  end

endmodule

`default_nettype wire

// ===== src/path_point_box_smoother.sv =====
// Results come from the bit-serial divider in the back, which works on one job at a time.
// The front takes a new point only once it has classified the last one and queued every
//   job that point released.
// Reset: asynchronous, active low; half_window returns to 7 and the stroke is empty.
// ----------------------------------------------------------------------------
// path_point_box_smoother
// Centered moving average over the points of a stroke, edges truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module path_point_box_smoother import pbs_pkg::*; #(
  parameter int MAX_HALF_WINDOW   = MAX_HALF_WINDOW_DEF,
  parameter int MAX_STROKE_POINTS = MAX_STROKE_POINTS_DEF,
  parameter int COORD_BITS        = COORD_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pbs_cfg_if.sink     cfg_i,
  pbs_point_if.sink   in_i,
  pbs_smooth_if.source out_o
);

  // The count of points in a window reaches 2*h+1, and a window sum holds
  // at most that many coordinates, so both widths follow from the maximum
  // half-window.
  localparam int CNT_W = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int SUM_W = COORD_BITS + CNT_W;
  localparam int JOB_W = 2 * SUM_W + CNT_W + 1;

  // The half-window register. It is sampled by the front only at the first
  // point of a stroke, so a write in mid-stroke applies to the next stroke.
  logic [CFG_W-1:0] half_window_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_window_q <= HALF_WINDOW_RESET;
    end else if (cfg_i.valid) begin
      half_window_q <= cfg_i.half_window;
    end
  end

  logic             job_push_valid, job_push_ready;
  logic [JOB_W-1:0] job_push_data;
  logic             job_pop_valid, job_pop_ready;
  logic [JOB_W-1:0] job_pop_data;

  // The front takes each input beat, writes the point into the ring,
  // updates the running sums and decides how many points it releases: one
  // once the window ahead of the oldest pending point is full, or all
  // pending points when the beat closes the stroke. For every released
  // point it queues a job holding both sums, the count and the end flag,
  // then slides the window by reading the leaving and entering points.
  pbs_front #(
    .MAX_HALF_WINDOW   (MAX_HALF_WINDOW),
    .MAX_STROKE_POINTS (MAX_STROKE_POINTS),
    .COORD_BITS        (COORD_BITS),
    .CNT_W             (CNT_W),
    .SUM_W             (SUM_W),
    .JOB_W             (JOB_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .half_window_i (half_window_q),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .point_x_i     (in_i.point_x),
    .point_y_i     (in_i.point_y),
    .last_point_i  (in_i.last_point),
    .job_valid_o   (job_push_valid),
    .job_ready_i   (job_push_ready),
    .job_data_o    (job_push_data)
  );

  // The queue lets the front keep taking points while the divider works.
  pbs_fifo #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_push_valid),
    .push_ready_o (job_push_ready),
    .push_data_i  (job_push_data),
    .pop_valid_o  (job_pop_valid),
    .pop_ready_i  (job_pop_ready),
    .pop_data_o   (job_pop_data)
  );

  // The back divides both sums by the count with two lockstep bit-serial
  // restoring dividers and parks the means in the output register, which
  // keeps its beat stable until the sink takes it.
  pbs_back #(
    .COORD_BITS (COORD_BITS),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_pop_valid),
    .job_ready_o  (job_pop_ready),
    .job_data_i   (job_pop_data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .smooth_x_o   (out_o.smooth_x),
    .smooth_y_o   (out_o.smooth_y),
    .stroke_end_o (out_o.stroke_end)
  );

endmodule

`default_nettype wire

// ===== src/pbs_checker.sv =====
// ----------------------------------------------------------------------------
// pbs_checker
// Port-level checks of the smoother, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pbs_checker #(
  parameter int COORD_BITS = 14
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_ready_i,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_i,
  input wire logic                  out_valid_i,
  input wire logic                  out_ready_i,
  input wire logic [COORD_BITS-1:0] smooth_x_i,
  input wire logic [COORD_BITS-1:0] smooth_y_i,
  input wire logic                  stroke_end_i
);

  // The register port never stalls a write.
  `PBS_ASSERT_IMP(a_cfg_always_ready, 1'b1, cfg_ready_i)

  // Each accepted point is classified before the next one is taken.
  `PBS_ASSERT_NXT(a_in_gap_after_beat, in_valid_i && in_ready_i, !in_ready_i)

  // A stalled result beat holds.
  `PBS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(smooth_x_i) && $stable(smooth_y_i) && $stable(stroke_end_i))

endmodule

bind path_point_box_smoother pbs_checker #(
  .COORD_BITS (COORD_BITS)
) u_pbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_i  (cfg_i.ready),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .smooth_x_i   (out_o.smooth_x),
  .smooth_y_i   (out_o.smooth_y),
  .stroke_end_i (out_o.stroke_end)
);

`default_nettype wire
